// ===== hdl/greedy_voxel_mesher_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the greedy voxel mesher.
// Each macro checks a property on the rising clock edge outside of reset.
// ----------------------------------------------------------------------------
`ifndef GREEDY_VOXEL_MESHER_TOP_DEFINES_SVH
`define GREEDY_VOXEL_MESHER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GVM_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GVM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/gvm_pkg.sv =====
// ----------------------------------------------------------------------------
// gvm_pkg
// Shared constants, types and helpers of the greedy voxel mesher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gvm_pkg;

   localparam int CHUNK_EDGE_DEF = 16;
   localparam int QUAD_W         = 14;
   localparam int COORD_W        = 5;
   localparam int REQ_DATA_W     = 24;
   localparam int RSP_DATA_W     = 48;
   localparam int RSP_USER_W     = 2;

   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_REQUEST = 1'b1;

   localparam logic [1:0] MASK_NONE = 2'd0;
   localparam logic [1:0] MASK_POS  = 2'd1;
   localparam logic [1:0] MASK_NEG  = 2'd2;

   localparam logic [1:0] SWEEP_DONE = 2'd3;

   typedef enum logic [9:0] {
      ST_CLEAR   = 10'b00_0000_0001,
      ST_IDLE    = 10'b00_0000_0010,
      ST_START   = 10'b00_0000_0100,
      ST_BLD_RD  = 10'b00_0000_1000,
      ST_BLD_DT  = 10'b00_0001_0000,
      ST_SCAN_RD = 10'b00_0010_0000,
      ST_SCAN_DT = 10'b00_0100_0000,
      ST_HGT_RD  = 10'b00_1000_0000,
      ST_HGT_DT  = 10'b01_0000_0000,
      ST_EMIT    = 10'b10_0000_0000
   } state_type;

   // Axis assignment per sweep: slot 0 is U, slot 1 is V, slot 2 is W.
   function automatic logic [1:0] axis_of(input logic [1:0] sweep, input int slot);
      logic [1:0] res;
      res = 2'd0;
      case (sweep)
         2'd0: res = (slot == 0) ? 2'd0 : (slot == 1) ? 2'd1 : 2'd2;
         2'd1: res = (slot == 0) ? 2'd0 : (slot == 1) ? 2'd2 : 2'd1;
         2'd2: res = (slot == 0) ? 2'd1 : (slot == 1) ? 2'd2 : 2'd0;
         default: res = 2'd0;
      endcase
      return res;
   endfunction

   function automatic logic [1:0] cell_code(input logic s0, input logic s1);
      logic [1:0] res;
      if (s0 == s1) begin
         res = MASK_NONE;
      end else if (s0) begin
         res = MASK_POS;
      end else begin
         res = MASK_NEG;
      end
      return res;
   endfunction

endpackage

// ===== hdl/gvm_ram.sv =====
// ----------------------------------------------------------------------------
// gvm_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gvm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/greedy_voxel_mesher_top.sv =====
// ----------------------------------------------------------------------------
// greedy_voxel_mesher_top
// Greedy quad mesher for a cubic voxel chunk held in on-chip memory.
// ----------------------------------------------------------------------------
// The request channel carries a command in req_tuser. A load transfer writes
// one x-row of solidity at (row_y, row_z) and rewinds the traversal; it gives
// no result. A request transfer starts a search for the next merged quad and
// gives exactly one result transfer: a quad, or an end marker once all three
// sweeps are done.
// Building a slice mask takes two voxel row reads per mask row in the first
// two sweeps and one per cell in the third, since each cell there needs its
// own voxel row read. Scanning reads each mask row that it visits, and each
// stacked row of a quad takes one more mask row read.
// After reset the voxel memory is cleared one row per cycle; no transfer is
// accepted meanwhile. A finished result sits in an output register, so loads
// are taken while the receiver stalls; a new result waits for that register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module greedy_voxel_mesher_top #(
   parameter int CHUNK_EDGE = gvm_pkg::CHUNK_EDGE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // row_y [3:0], row_z [7:4], row_bits [23:8]
   input  logic [gvm_pkg::REQ_DATA_W-1:0]  req_tdata,
   // cmd [0]
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // normal_axis [1:0], normal_positive [2], corner_x [7:3], corner_y [12:8],
   // corner_z [17:13], extent_u [22:18], extent_v [27:23], quad_number [41:28]
   output logic [gvm_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // has_quad [0], end_of_mesh [1]
   output logic [gvm_pkg::RSP_USER_W-1:0]  rsp_tuser
);

   import gvm_pkg::*;

   localparam int N  = CHUNK_EDGE;
   localparam int CW = $clog2(N);
   localparam int PW = CW + 1;
   localparam int AW = 2 * CW;
   localparam int VDEPTH = 1 << AW;
   localparam int MDEPTH = 1 << CW;

   state_type state_ff, state_in;

   logic [1:0]        axis_ff, axis_in;
   logic [PW-1:0]     plane_ff, plane_in;
   logic [PW-1:0]     scan_v_ff, scan_v_in;
   logic [PW-1:0]     scan_u_ff, scan_u_in;
   logic              mask_ready_ff, mask_ready_in;
   logic [QUAD_W-1:0] quad_cnt_ff, quad_cnt_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic [PW-1:0]     bv_ff, bv_in;
   logic [PW-1:0]     bk_ff, bk_in;
   logic [N-1:0]      lo_ff, lo_in;
   logic [2*N-1:0]    mrow_ff, mrow_in;
   logic [CW-1:0]     qu_ff, qu_in;
   logic [PW-1:0]     qw_ff, qw_in;
   logic [CW-1:0]     qv_ff, qv_in;
   logic [PW-1:0]     qh_ff, qh_in;
   logic [1:0]        qc_ff, qc_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   logic           vox_we;
   logic [AW-1:0]  vox_waddr, vox_raddr;
   logic [N-1:0]   vox_wdata, vox_rdata;
   logic           mask_we;
   logic [CW-1:0]  mask_waddr, mask_raddr;
   logic [2*N-1:0] mask_wdata, mask_rdata;

   gvm_ram #(.WIDTH(N), .DEPTH(VDEPTH)) u_voxel_ram (
      .clock (clock),
      .we    (vox_we),
      .waddr (vox_waddr),
      .wdata (vox_wdata),
      .raddr (vox_raddr),
      .rdata (vox_rdata)
   );

   gvm_ram #(.WIDTH(2 * N), .DEPTH(MDEPTH)) u_mask_ram (
      .clock (clock),
      .we    (mask_we),
      .waddr (mask_waddr),
      .wdata (mask_wdata),
      .raddr (mask_raddr),
      .rdata (mask_rdata)
   );

   logic           req_fire;
   logic           out_free;
   logic [PW-1:0]  layer;
   logic           layer_ok;
   logic [N-1:0]   layer_row;
   logic           s0, s1;
   logic [2*N-1:0] bld_row;
   logic [N-1:0]   nz;
   logic           found;
   logic [CW-1:0]  fu;
   logic [1:0]     fc;
   logic [PW-1:0]  fstop;
   logic [2*N-1:0] scan_clr;
   logic           hgt_match;
   logic [2*N-1:0] hgt_clr;
   logic [PW-1:0]  qend;
   logic [PW-1:0]  coord_u, coord_v, coord_w;
   logic [COORD_W-1:0] corner [3];
   logic [1:0]     ax_u, ax_v, ax_w;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Layer of the current read in the first two sweeps.
   assign layer    = (bk_ff == '0) ? (plane_ff - PW'(1)) : plane_ff;
   assign layer_ok = (bk_ff == '0) ? (plane_ff != '0) : (plane_ff != PW'(N));
   assign layer_row = layer_ok ? vox_rdata : '0;
   assign s0 = (plane_ff != '0) ? vox_rdata[CW'(plane_ff - PW'(1))] : 1'b0;
   assign s1 = (plane_ff != PW'(N)) ? vox_rdata[CW'(plane_ff)] : 1'b0;
   assign qend = PW'(qu_ff) + qw_ff;

   always_comb begin
      vox_raddr = '0;
      if (axis_ff == 2'd0) begin
         vox_raddr = {CW'(layer), CW'(bv_ff)};
      end else if (axis_ff == 2'd1) begin
         vox_raddr = {CW'(bv_ff), CW'(layer)};
      end else begin
         vox_raddr = {CW'(bv_ff), CW'(bk_ff)};
      end
   end

   always_comb begin
      bld_row = mrow_ff;
      if (axis_ff == 2'd2) begin
         for (int u = 0; u < N; u++) begin
            if (PW'(u) == bk_ff) begin
               bld_row[2*u +: 2] = cell_code(s0, s1);
            end
         end
      end else begin
         for (int u = 0; u < N; u++) begin
            bld_row[2*u +: 2] = cell_code(lo_ff[u], layer_row[u]);
         end
      end
   end

   always_comb begin
      found = 1'b0;
      fu    = '0;
      for (int u = N - 1; u >= 0; u--) begin
         nz[u] = (mask_rdata[2*u +: 2] != MASK_NONE) && (PW'(u) >= scan_u_ff);
         if (nz[u]) begin
            found = 1'b1;
            fu    = CW'(u);
         end
      end
      fc    = mask_rdata[2*fu +: 2];
      fstop = PW'(N);
      for (int u = N - 1; u >= 0; u--) begin
         if ((PW'(u) > PW'(fu)) && (mask_rdata[2*u +: 2] != fc)) begin
            fstop = PW'(u);
         end
      end
      scan_clr = mask_rdata;
      for (int u = 0; u < N; u++) begin
         if ((PW'(u) >= PW'(fu)) && (PW'(u) < fstop)) begin
            scan_clr[2*u +: 2] = MASK_NONE;
         end
      end
   end

   always_comb begin
      hgt_match = 1'b1;
      hgt_clr   = mask_rdata;
      for (int u = 0; u < N; u++) begin
         if ((PW'(u) >= PW'(qu_ff)) && (PW'(u) < qend)) begin
            hgt_clr[2*u +: 2] = MASK_NONE;
            if (mask_rdata[2*u +: 2] != qc_ff) begin
               hgt_match = 1'b0;
            end
         end
      end
   end

   always_comb begin
      ax_u    = axis_of(axis_ff, 0);
      ax_v    = axis_of(axis_ff, 1);
      ax_w    = axis_of(axis_ff, 2);
      coord_u = PW'(qu_ff);
      coord_v = PW'(qv_ff);
      coord_w = plane_ff;
      for (int d = 0; d < 3; d++) begin
         if (ax_u == 2'(d)) begin
            corner[d] = COORD_W'(coord_u);
         end else if (ax_v == 2'(d)) begin
            corner[d] = COORD_W'(coord_v);
         end else begin
            corner[d] = COORD_W'(coord_w);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      axis_in       = axis_ff;
      plane_in      = plane_ff;
      scan_v_in     = scan_v_ff;
      scan_u_in     = scan_u_ff;
      mask_ready_in = mask_ready_ff;
      quad_cnt_in   = quad_cnt_ff;
      clr_in        = clr_ff;
      bv_in         = bv_ff;
      bk_in         = bk_ff;
      lo_in         = lo_ff;
      mrow_in       = mrow_ff;
      qu_in         = qu_ff;
      qw_in         = qw_ff;
      qv_in         = qv_ff;
      qh_in         = qh_ff;
      qc_in         = qc_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      vox_we        = 1'b0;
      vox_waddr     = clr_ff;
      vox_wdata     = '0;
      mask_we       = 1'b0;
      mask_waddr    = CW'(bv_ff);
      mask_wdata    = bld_row;
      mask_raddr    = CW'(scan_v_ff);

      case (state_ff)
         ST_CLEAR: begin
            vox_we = 1'b1;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(VDEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == CMD_LOAD) begin
                  vox_waddr = {CW'(req_tdata[7:4]), CW'(req_tdata[3:0])};
                  vox_wdata = N'(req_tdata[23:8]);
                  vox_we    = (32'(req_tdata[3:0]) < 32'(N)) &&
                              (32'(req_tdata[7:4]) < 32'(N));
                  axis_in       = 2'd0;
                  plane_in      = '0;
                  scan_u_in     = '0;
                  scan_v_in     = '0;
                  mask_ready_in = 1'b0;
                  quad_cnt_in   = '0;
               end else begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            if (axis_ff == SWEEP_DONE) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
                  rsp_user_in  = 2'b10;
                  state_in     = ST_IDLE;
               end
            end else if (!mask_ready_ff) begin
               bv_in    = '0;
               bk_in    = '0;
               state_in = ST_BLD_RD;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_BLD_RD: begin
            state_in = ST_BLD_DT;
         end
         ST_BLD_DT: begin
            if ((axis_ff != 2'd2) && (bk_ff == '0)) begin
               lo_in    = layer_row;
               bk_in    = PW'(1);
               state_in = ST_BLD_RD;
            end else if ((axis_ff == 2'd2) && (bk_ff != PW'(N - 1))) begin
               mrow_in  = bld_row;
               bk_in    = bk_ff + PW'(1);
               state_in = ST_BLD_RD;
            end else begin
               mask_we = 1'b1;
               bk_in   = '0;
               if (bv_ff == PW'(N - 1)) begin
                  mask_ready_in = 1'b1;
                  scan_u_in     = '0;
                  scan_v_in     = '0;
                  state_in      = ST_SCAN_RD;
               end else begin
                  bv_in    = bv_ff + PW'(1);
                  state_in = ST_BLD_RD;
               end
            end
         end
         ST_SCAN_RD: begin
            if (scan_v_ff == PW'(N)) begin
               mask_ready_in = 1'b0;
               scan_u_in     = '0;
               scan_v_in     = '0;
               if (plane_ff == PW'(N)) begin
                  plane_in = '0;
                  axis_in  = axis_ff + 2'd1;
               end else begin
                  plane_in = plane_ff + PW'(1);
               end
               state_in = ST_START;
            end else begin
               state_in = ST_SCAN_DT;
            end
         end
         ST_SCAN_DT: begin
            if (found) begin
               mask_we    = 1'b1;
               mask_waddr = CW'(scan_v_ff);
               mask_wdata = scan_clr;
               qu_in      = fu;
               qw_in      = fstop - PW'(fu);
               qv_in      = CW'(scan_v_ff);
               qc_in      = fc;
               qh_in      = PW'(1);
               if (scan_v_ff == PW'(N - 1)) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_HGT_RD;
               end
            end else begin
               scan_v_in = scan_v_ff + PW'(1);
               scan_u_in = '0;
               state_in  = ST_SCAN_RD;
            end
         end
         ST_HGT_RD: begin
            mask_raddr = CW'(PW'(qv_ff) + qh_ff);
            state_in   = ST_HGT_DT;
         end
         ST_HGT_DT: begin
            if (hgt_match) begin
               mask_we    = 1'b1;
               mask_waddr = CW'(PW'(qv_ff) + qh_ff);
               mask_wdata = hgt_clr;
               qh_in      = qh_ff + PW'(1);
               if ((PW'(qv_ff) + qh_ff) == PW'(N - 1)) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_HGT_RD;
               end
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = 2'b01;
               rsp_data_in  = {6'b0, quad_cnt_ff, COORD_W'(qh_ff), COORD_W'(qw_ff),
                               corner[2], corner[1], corner[0],
                               (qc_ff == MASK_POS), ax_w};
               quad_cnt_in  = quad_cnt_ff + QUAD_W'(1);
               if (qend == PW'(N)) begin
                  scan_u_in = '0;
                  scan_v_in = PW'(qv_ff) + PW'(1);
               end else begin
                  scan_u_in = qend;
                  scan_v_in = PW'(qv_ff);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         axis_ff       <= 2'd0;
         plane_ff      <= '0;
         scan_v_ff     <= '0;
         scan_u_ff     <= '0;
         mask_ready_ff <= 1'b0;
         quad_cnt_ff   <= '0;
         clr_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         axis_ff       <= axis_in;
         plane_ff      <= plane_in;
         scan_v_ff     <= scan_v_in;
         scan_u_ff     <= scan_u_in;
         mask_ready_ff <= mask_ready_in;
         quad_cnt_ff   <= quad_cnt_in;
         clr_ff        <= clr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bv_ff       <= bv_in;
      bk_ff       <= bk_in;
      lo_ff       <= lo_in;
      mrow_ff     <= mrow_in;
      qu_ff       <= qu_in;
      qw_ff       <= qw_in;
      qv_ff       <= qv_in;
      qh_ff       <= qh_in;
      qc_ff       <= qc_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

`include "greedy_voxel_mesher_top_defines.svh"

   `GVM_ASSERT_NOW(a_quad_or_end, rsp_tvalid, !(rsp_tuser[0] && rsp_tuser[1]), "quad and end marker together")
   `GVM_ASSERT_NOW(a_extent_nonzero, rsp_tvalid && rsp_tuser[0], (rsp_tdata[22:18] != '0) && (rsp_tdata[27:23] != '0), "quad with zero extent")
   `GVM_ASSERT_NEXT(a_load_rewinds, req_tvalid && req_tready && (req_tuser == CMD_LOAD), (quad_cnt_ff == '0) && !mask_ready_ff && (axis_ff == 2'd0), "load did not rewind traversal")
   `GVM_ASSERT_NOW(a_stack_in_range, state_ff == ST_HGT_RD, (qh_ff != '0) && ((PW'(qv_ff) + qh_ff) < PW'(N)), "stacked row outside chunk")

endmodule

// ===== tb/tb_greedy_voxel_mesher_top.sv =====
// ----------------------------------------------------------------------------
// Testbench for greedy_voxel_mesher_top
// Loads sparse voxel chunks and requests merged quads. Every result transfer
// is checked field by field against a behavioral mesher kept in the bench.
// Both sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_greedy_voxel_mesher_top;
   import gvm_pkg::*;

   localparam int EDGE = 16;
   localparam int CELL_COUNT = EDGE * EDGE;

   typedef struct {
      logic       hold;
      logic       cmd;
      logic [3:0] y;
      logic [3:0] z;
      logic [15:0] bits;
   } mesh_cmd_type;

   typedef struct {
      logic        has_quad;
      logic [1:0]  axis;
      logic        positive;
      logic [4:0]  cx, cy, cz, eu, ev;
      logic [13:0] qnum;
      logic        eom;
   } quad_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   greedy_voxel_mesher_top uut (.*);

   always #6 clock = ~clock;

   // Mesher state mirrored in the bench.
   logic [15:0] chunk_rows [CELL_COUNT];
   logic [1:0]  face_mask [CELL_COUNT];
   int          cur_sweep, cur_slice, pos_u, pos_v;
   logic        mask_built;
   logic [13:0] quad_count;

   mesh_cmd_type pending_cmds [$];
   quad_type     expected_quads [$];
   mesh_cmd_type in_flight;
   int          error_count = 0;
   int          gap_left = 0;
   logic        burst_mode = 1'b0;

   function automatic int axis_map(int sweep, int slot);
      int amap [3][3] = '{'{0, 1, 2}, '{0, 2, 1}, '{1, 2, 0}};
      return amap[sweep][slot];
   endfunction

   function automatic logic voxel_solid(int p [3]);
      if (p[0] < 0 || p[1] < 0 || p[2] < 0) return 1'b0;
      if (p[0] >= EDGE || p[1] >= EDGE || p[2] >= EDGE) return 1'b0;
      return chunk_rows[p[2] * EDGE + p[1]][p[0]];
   endfunction

   function automatic void build_face_mask();
      int p0 [3];
      int p1 [3];
      logic s0, s1;
      for (int v = 0; v < EDGE; v++) begin
         for (int u = 0; u < EDGE; u++) begin
            p0[axis_map(cur_sweep, 0)] = u;
            p0[axis_map(cur_sweep, 1)] = v;
            p0[axis_map(cur_sweep, 2)] = cur_slice;
            p1 = p0;
            p1[axis_map(cur_sweep, 2)] = cur_slice + 1;
            s0 = voxel_solid(p0);
            s1 = voxel_solid(p1);
            face_mask[v * EDGE + u] = (s0 == s1) ? MASK_NONE : (s0 ? MASK_POS : MASK_NEG);
         end
      end
   endfunction

   function automatic void rewind_mesh();
      cur_sweep = 0;
      cur_slice = -1;
      pos_u = 0;
      pos_v = 0;
      mask_built = 1'b0;
      quad_count = '0;
   endfunction

   function automatic quad_type next_quad();
      quad_type q;
      int idx, u, v, w, h, corner [3];
      logic [1:0] c;
      logic stop;
      q = '{default: '0};
      forever begin
         if (cur_sweep >= 3) begin
            q.eom = 1'b1;
            return q;
         end
         if (!mask_built) begin
            build_face_mask();
            mask_built = 1'b1;
            pos_u = 0;
            pos_v = 0;
         end
         for (idx = pos_v * EDGE + pos_u; idx < CELL_COUNT; idx++)
            if (face_mask[idx] != MASK_NONE) break;
         if (idx < CELL_COUNT) begin
            u = idx % EDGE;
            v = idx / EDGE;
            c = face_mask[idx];
            w = 1;
            h = 1;
            stop = 1'b0;
            while (u + w < EDGE && face_mask[idx + w] == c) w++;
            while (v + h < EDGE && !stop) begin
               for (int k = 0; k < w; k++)
                  if (face_mask[(v + h) * EDGE + u + k] != c) stop = 1'b1;
               if (!stop) h++;
            end
            for (int r = 0; r < h; r++)
               for (int k = 0; k < w; k++) face_mask[(v + r) * EDGE + u + k] = MASK_NONE;
            corner[axis_map(cur_sweep, 0)] = u;
            corner[axis_map(cur_sweep, 1)] = v;
            corner[axis_map(cur_sweep, 2)] = cur_slice + 1;
            q.has_quad = 1'b1;
            q.axis = 2'(axis_map(cur_sweep, 2));
            q.positive = (c == MASK_POS);
            q.cx = 5'(corner[0]);
            q.cy = 5'(corner[1]);
            q.cz = 5'(corner[2]);
            q.eu = 5'(w);
            q.ev = 5'(h);
            q.qnum = quad_count;
            quad_count++;
            pos_u = u + w;
            pos_v = v;
            if (pos_u >= EDGE) begin
               pos_u = 0;
               pos_v = v + 1;
            end
            return q;
         end
         mask_built = 1'b0;
         pos_u = 0;
         pos_v = 0;
         if (cur_slice >= EDGE - 1) begin
            cur_slice = -1;
            cur_sweep++;
         end else begin
            cur_slice++;
         end
      end
   endfunction

   function automatic void apply_transfer(mesh_cmd_type m);
      if (m.cmd == CMD_LOAD) begin
         chunk_rows[m.z * EDGE + m.y] = m.bits;
         rewind_mesh();
      end else begin
         expected_quads.insert(expected_quads.size(), next_quad());
      end
   endfunction

   function automatic int pick_gap();
      if (($urandom % 40) == 0) burst_mode = ~burst_mode;
      if (burst_mode) return 0;
      if (($urandom % 12) == 0) return $urandom_range(20, 60);
      return $urandom_range(0, 3);
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) apply_transfer(in_flight);
         if (req_tvalid && !req_tready) begin
         end else if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_cmds.size() > 0 && pending_cmds[0].hold) begin
            if (expected_quads.size() == 0) void'(pending_cmds.pop_front());
            req_tvalid <= 1'b0;
         end else if (pending_cmds.size() > 0) begin
            in_flight = pending_cmds.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= in_flight.cmd;
            req_tdata <= {in_flight.bits, in_flight.z, in_flight.y};
            gap_left = pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      quad_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.has_quad = rsp_tuser[0];
            got.eom = rsp_tuser[1];
            got.axis = rsp_tdata[1:0];
            got.positive = rsp_tdata[2];
            got.cx = rsp_tdata[7:3];
            got.cy = rsp_tdata[12:8];
            got.cz = rsp_tdata[17:13];
            got.eu = rsp_tdata[22:18];
            got.ev = rsp_tdata[27:23];
            got.qnum = rsp_tdata[41:28];
            if (expected_quads.size() == 0) begin
               report_mismatch("unexpected result transfers", 1, 0);
            end else begin
               want = expected_quads.pop_front();
               if (got.has_quad !== want.has_quad) report_mismatch("has_quad", got.has_quad, want.has_quad);
               if (got.eom !== want.eom) report_mismatch("end_of_mesh", got.eom, want.eom);
               if (got.axis !== want.axis) report_mismatch("normal_axis", got.axis, want.axis);
               if (got.positive !== want.positive) report_mismatch("normal_positive", got.positive, want.positive);
               if (got.cx !== want.cx) report_mismatch("corner_x", got.cx, want.cx);
               if (got.cy !== want.cy) report_mismatch("corner_y", got.cy, want.cy);
               if (got.cz !== want.cz) report_mismatch("corner_z", got.cz, want.cz);
               if (got.eu !== want.eu) report_mismatch("extent_u", got.eu, want.eu);
               if (got.ev !== want.ev) report_mismatch("extent_v", got.ev, want.ev);
               if (got.qnum !== want.qnum) report_mismatch("quad_number", got.qnum, want.qnum);
            end
         end
         if (($urandom % 50) == 0) rsp_tready <= 1'b0;
         else if (($urandom % 8) == 0) rsp_tready <= ~rsp_tready;
         else if (!rsp_tready && ($urandom % 3) == 0) rsp_tready <= 1'b1;
      end
   end

   task automatic queue_load(int y, int z, logic [15:0] bits);
      pending_cmds.insert(pending_cmds.size(),
                          mesh_cmd_type'{1'b0, CMD_LOAD, 4'(y), 4'(z), bits});
   endtask

   task automatic queue_request();
      pending_cmds.insert(pending_cmds.size(),
                          mesh_cmd_type'{1'b0, CMD_REQUEST, 4'($urandom), 4'($urandom),
                                         16'($urandom)});
   endtask

   task automatic queue_hold();
      pending_cmds.insert(pending_cmds.size(),
                          mesh_cmd_type'{1'b1, CMD_REQUEST, 4'd0, 4'd0, 16'd0});
   endtask

   function automatic logic [15:0] sparse_row();
      int lo, len;
      case ($urandom % 4)
         0: return 16'(1) << $urandom_range(0, 15);
         1: begin
            lo = $urandom_range(0, 15);
            len = $urandom_range(1, 16 - lo);
            return 16'(((32'(1) << len) - 1) << lo);
         end
         2: return 16'($urandom) & 16'($urandom) & 16'($urandom);
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      int total, n, used_y [$], used_z [$];
      rewind_mesh();
      foreach (chunk_rows[i]) chunk_rows[i] = '0;

      // Empty chunk, then corner rows and extreme patterns.
      queue_request();
      queue_request();
      queue_load(0, 0, 16'h0001);
      queue_load(15, 15, 16'hFFFF);
      queue_load(3, 7, 16'hAAAA);
      queue_load(7, 3, 16'h8000);
      for (int i = 0; i < 12; i++) queue_request();
      queue_hold();
      queue_load(0, 0, 16'h0000);
      for (int i = 0; i < 6; i++) queue_request();
      total = 24;
      used_y = '{0, 15, 3, 7};
      used_z = '{0, 15, 7, 3};

      while (total < 600) begin
         while (used_y.size() > 0) begin
            queue_load(used_y.pop_front(), used_z.pop_front(), 16'h0000);
            total++;
         end
         n = $urandom_range(1, 4);
         for (int i = 0; i < n; i++) begin
            used_y.insert(used_y.size(), $urandom_range(0, 15));
            used_z.insert(used_z.size(), $urandom_range(0, 15));
            queue_load(used_y[i], used_z[i], sparse_row());
            total++;
         end
         n = $urandom_range(1, 40);
         for (int i = 0; i < n; i++) begin
            if (($urandom % 25) == 0) begin
               used_y.insert(used_y.size(), $urandom_range(0, 15));
               used_z.insert(used_z.size(), $urandom_range(0, 15));
               queue_load(used_y[$], used_z[$], sparse_row());
            end else begin
               queue_request();
            end
            total++;
         end
         if (($urandom % 6) == 0) queue_hold();
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      while (pending_cmds.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_quads.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #400ms;
      $display("timeout at %0t", $realtime);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/gvm_pkg.sv
hdl/gvm_ram.sv
hdl/greedy_voxel_mesher_top.sv
tb/tb_greedy_voxel_mesher_top.sv
